### hdl/aro_pkg.sv
package aro_pkg;

	localparam int TimeW  = 48;
	localparam int AccW   = 24;
	localparam int GapW   = 32;
	localparam int GainW  = 16;
	localparam int ValW   = 25;
	localparam int EntryW = 2 * TimeW + AccW;

	typedef enum logic [1:0] {
		KIND_CMD   = 2'd0,
		KIND_OBS   = 2'd1,
		KIND_RESET = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CMD_OK   = 3'd0,
		ST_CMD_REJ  = 3'd1,
		ST_OBS_OK   = 3'd2,
		ST_NO_OBS   = 3'd3,
		ST_RESET    = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		REG_GAIN = 1'd0,
		REG_GAP  = 1'd1
	} reg_t;

	typedef struct packed {
		logic [TimeW-1:0] pub;
		logic [TimeW-1:0] start;
		logic signed [AccW-1:0] acc;
	} entry_t;

	typedef struct packed {
		logic       start;
		logic       is_signed;
		logic [63:0] num;
		logic [47:0] den;
	} div_req_t;

	function automatic logic signed [AccW-1:0] sat24(input logic signed [71:0] v);
		logic signed [71:0] hi;
		logic signed [71:0] lo;
		begin
			hi = 72'sd8388607;
			lo = -72'sd8388608;
			if (v > hi) sat24 = 24'sh7FFFFF;
			else if (v < lo) sat24 = 24'sh800000;
			else sat24 = v[AccW-1:0];
		end
	endfunction

endpackage

### hdl/aro_ram.sv
module aro_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

### hdl/aro_div.sv
module aro_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  aro_pkg::div_req_t       req,
	output logic                    busy,
	output logic signed [71:0]      quot
);
	import aro_pkg::*;

	logic [63:0] rem_q;
	logic [63:0] q_q;
	logic [47:0] den_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic [63:0] shifted;
	logic [48:0] trial;
	logic [64:0] rshift;

	always_comb begin
		rshift  = {rem_q, q_q[63]};
		shifted = q_q << 1;
		trial   = rshift[48:0] - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else if (req.start) begin
			cnt_q <= 7'd64;
			neg_q <= req.is_signed & req.num[63];
		end else if (cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= (req.is_signed && req.num[63]) ? (~req.num + 64'd1) : req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (cnt_q != 7'd0) begin
			if (!trial[48] || rshift[64:49] != 16'd0) begin
				rem_q <= {15'd0, trial};
				q_q   <= shifted | 64'd1;
			end else begin
				rem_q <= rshift[63:0];
				q_q   <= shifted;
			end
		end
	end

	assign busy = (cnt_q != 7'd0);
	assign quot = neg_q ? -$signed({8'd0, q_q}) : $signed({8'd0, q_q});
endmodule

### hdl/accel_response_observer.sv
// A command walks through the entry RAM; an observation may walk it too and then runs
// two 64-step serial divisions, one after the other.
// Throughput: one transaction at a time; s_axis_tready is low while one is in flight.
// Output result sits in a register; the next transaction is taken once it is accepted downstream.
// arst_n clears control and observer state; command RAM contents are undefined until written.
module accel_response_observer #(
	parameter int CMD_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// event_time[47:0], origin_time[95:48], value[120:96], zero fill
	input  logic [127:0] s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[2:0], observed_time[50:3], observed_speed[74:51],
	// filt_measured[98:75], filt_commanded[122:99], zero fill
	output logic [127:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);
	import aro_pkg::*;

	localparam int AW = $clog2(CMD_DEPTH);
	localparam int CW = $clog2(CMD_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_RLAST, S_CMDCHK, S_TRIMRD, S_TRIMCHK,
		S_INTRD, S_INTCHK, S_DIVM, S_DIVC, S_FILT, S_DONE
	} fsm_t;

	fsm_t state_q, state_d;

	logic [GainW-1:0] gain_q;
	logic [GapW-1:0]  gap_q;

	logic [1:0]       kind_q;
	logic [TimeW-1:0] et_q, ot_q;
	logic signed [ValW-1:0] val_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [TimeW-1:0] pobs_time_q;
	logic pobs_valid_q, obs_valid_q;
	logic [AccW-1:0] pspeed_q, ospeed_q;
	logic signed [AccW-1:0] fm_q, fc_q;

	logic [CW-1:0] idx_q;
	logic signed [AccW-1:0] acc_q;
	logic signed [71:0] sum_q;
	logic [TimeW-1:0] cur_q;
	logic [TimeW-1:0] dt_q;
	logic signed [AccW-1:0] meas_q;

	logic [2:0] ostatus_q;
	logic ovalid_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata, ram_rd;
	logic [EntryW-1:0] ram_rdata;

	div_req_t dreq;
	logic dbusy;
	logic signed [71:0] dquot;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		begin
			s = {1'b0, {(CW-AW){1'b0}}, h} + {1'b0, i};
			if (s >= (CW+1)'(CMD_DEPTH)) s = s - (CW+1)'(CMD_DEPTH);
			slot = s[AW-1:0];
		end
	endfunction

	aro_ram #(.Width(EntryW), .Depth(CMD_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);
	assign ram_rd = entry_t'(ram_rdata);

	aro_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quot(dquot));

	assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	wire s_acc = s_axis_tvalid && s_axis_tready;

	wire [TimeW-1:0] e_pub = et_q;
	wire [TimeW-1:0] e_start = ot_q;
	wire signed [AccW-1:0] e_acc = sat24(72'(val_q));
	wire [TimeW:0] trim_lim = {1'b0, ram_rd.start} + {17'd0, gap_q};
	wire [TimeW-1:0] obs_dt = et_q - pobs_time_q;
	wire [TimeW-1:0] iend = et_q;
	// segments never span more than max_gap
	wire [GapW-1:0] seg_end = GapW'(iend - cur_q);
	wire [GapW-1:0] seg_mid = GapW'(ram_rd.start - cur_q);

	logic [AW-1:0] cmd_wslot;
	logic cmd_clear, cmd_same, cmd_rej;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_acc) state_d = S_DISP;
			S_DISP: begin
				case (kind_t'(kind_q))
					KIND_CMD: state_d = (ot_q < et_q) ? S_DONE :
						(count_q != '0) ? S_RLAST : S_CMDCHK;
					KIND_OBS: begin
						if (val_q[ValW-1] || (pobs_valid_q && et_q < pobs_time_q) ||
							!pobs_valid_q || obs_dt > {16'd0, gap_q} || obs_dt == '0)
							state_d = S_DONE;
						else
							state_d = (count_q != '0) ? S_INTRD : S_DIVM;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_RLAST:  state_d = S_CMDCHK;
			S_CMDCHK: state_d = (ostatus_q == ST_CMD_REJ || cmd_rej) ? S_DONE : S_TRIMRD;
			S_TRIMRD: state_d = (count_q > (CW)'(1)) ? S_TRIMCHK : S_DONE;
			S_TRIMCHK: state_d = (trim_lim <= {1'b0, e_pub}) ? S_TRIMRD : S_DONE;
			S_INTRD:  state_d = S_INTCHK;
			S_INTCHK: state_d = (idx_q == count_q || ram_rd.start >= iend) ? S_DIVM : S_INTRD;
			S_DIVM:   if (!dbusy && !dreq.start) state_d = S_DIVC;
			S_DIVC:   if (!dbusy && !dreq.start) state_d = S_FILT;
			S_FILT:   state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	logic div_started_q;

	// RAM and divider control
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = slot(head_q, count_q);
		ram_wdata = '{pub: e_pub, start: e_start, acc: e_acc};
		ram_raddr = slot(head_q, count_q - (CW)'(1));
		dreq = '0;
		case (state_q)
			S_TRIMRD: ram_raddr = slot(head_q, (CW)'(1));
			S_TRIMCHK: ram_raddr = slot(head_q, (CW)'(2));
			S_INTRD: ram_raddr = slot(head_q, idx_q);
			S_DIVM: begin
				dreq.start = !div_started_q;
				dreq.is_signed = 1'b1;
				dreq.num = 64'(($signed({1'b0, val_q[AccW-1:0]}) -
					$signed({1'b0, pspeed_q})) * 64'sd1000000);
				dreq.den = dt_q;
			end
			S_DIVC: begin
				dreq.start = !div_started_q;
				dreq.is_signed = 1'b1;
				dreq.num = sum_q[63:0];
				dreq.den = dt_q;
			end
			default: ;
		endcase
		if (state_q == S_CMDCHK && ostatus_q != ST_CMD_REJ && !cmd_rej) begin
			ram_we = 1'b1;
			ram_waddr = cmd_wslot;
		end
	end

	always_comb begin
		cmd_clear = (count_q != '0) && (e_pub < ram_rd.pub);
		cmd_same  = (count_q != '0) && !cmd_clear && (e_pub == ram_rd.pub);
		cmd_rej = cmd_same ? (e_start != ram_rd.start) :
			((count_q != '0) && !cmd_clear && e_start < ram_rd.start);
		if (cmd_clear) cmd_wslot = '0;
		else if (cmd_same) cmd_wslot = slot(head_q, count_q - (CW)'(1));
		else if (count_q == (CW)'(CMD_DEPTH)) cmd_wslot = head_q;
		else cmd_wslot = slot(head_q, count_q);
	end

	// smoothing
	function automatic logic signed [AccW-1:0] smooth(input logic [GainW-1:0] g,
		input logic signed [AccW-1:0] p, input logic signed [AccW-1:0] n);
		logic signed [47:0] x;
		begin
			x = $signed({1'b0, g}) * p + $signed({1'b0, 17'd65536 - {1'b0, g}}) * n
				+ 48'sd32768;
			smooth = sat24(72'(x >>> 16));
		end
	endfunction

	wire signed [AccW-1:0] pm = obs_valid_q ? fm_q : '0;
	wire signed [AccW-1:0] pc = obs_valid_q ? fc_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gain_q <= '0;
			gap_q <= 32'd100000;
			head_q <= '0;
			count_q <= '0;
			pobs_time_q <= '0;
			pobs_valid_q <= 1'b0;
			pspeed_q <= '0;
			obs_valid_q <= 1'b0;
			fm_q <= '0;
			fc_q <= '0;
			ospeed_q <= '0;
			ovalid_q <= 1'b0;
			ostatus_q <= ST_NO_OBS;
			idx_q <= '0;
			div_started_q <= 1'b0;
			dt_q <= '0;
			acc_q <= '0;
			sum_q <= '0;
			cur_q <= '0;
			meas_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (reg_t'(cfg_index) == REG_GAIN) gain_q <= cfg_wdata[GainW-1:0];
				else gap_q <= cfg_wdata;
			end
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			div_started_q <= (state_q != state_d) ? 1'b0 : (div_started_q | dreq.start);
			case (state_q)
				S_DISP: begin
					idx_q <= '0;
					case (kind_t'(kind_q))
						KIND_CMD: ostatus_q <= (ot_q < et_q) ? ST_CMD_REJ : ST_CMD_OK;
						KIND_OBS: begin
							ostatus_q <= ST_NO_OBS;
							if (val_q[ValW-1]) begin
								head_q <= '0; count_q <= '0; pobs_time_q <= '0;
								pobs_valid_q <= 1'b0; pspeed_q <= '0; obs_valid_q <= 1'b0;
								fm_q <= '0; fc_q <= '0; ospeed_q <= '0;
							end else if (!pobs_valid_q || et_q < pobs_time_q ||
								obs_dt > {16'd0, gap_q}) begin
								if (pobs_valid_q && et_q < pobs_time_q) begin
									head_q <= '0; count_q <= '0;
									fm_q <= '0; fc_q <= '0; ospeed_q <= '0;
								end
								pobs_time_q <= et_q;
								pobs_valid_q <= 1'b1;
								pspeed_q <= val_q[AccW-1:0];
								obs_valid_q <= 1'b0;
							end else if (obs_dt == '0) begin
								pspeed_q <= val_q[AccW-1:0];
								if (obs_valid_q) begin
									ospeed_q <= val_q[AccW-1:0];
									ostatus_q <= ST_OBS_OK;
								end
							end else begin
								dt_q <= obs_dt;
								acc_q <= '0;
								sum_q <= '0;
								cur_q <= pobs_time_q;
							end
						end
						KIND_RESET: begin
							ostatus_q <= ST_RESET;
							head_q <= '0; count_q <= '0; pobs_time_q <= '0;
							pobs_valid_q <= 1'b0; pspeed_q <= '0; obs_valid_q <= 1'b0;
							fm_q <= '0; fc_q <= '0; ospeed_q <= '0;
						end
						default: ostatus_q <= ST_NO_OBS;
					endcase
				end
				S_CMDCHK: begin
					if (ostatus_q != ST_CMD_REJ) begin
						if (cmd_rej) ostatus_q <= ST_CMD_REJ;
						else if (cmd_clear) begin
							head_q <= '0; count_q <= (CW)'(1); pobs_time_q <= '0;
							pobs_valid_q <= 1'b0; pspeed_q <= '0; obs_valid_q <= 1'b0;
							fm_q <= '0; fc_q <= '0; ospeed_q <= '0;
						end else if (!cmd_same) begin
							if (count_q == (CW)'(CMD_DEPTH)) head_q <= slot(head_q, (CW)'(1));
							else count_q <= count_q + (CW)'(1);
						end
					end
				end
				S_TRIMCHK: begin
					if (trim_lim <= {1'b0, e_pub}) begin
						head_q <= slot(head_q, (CW)'(1));
						count_q <= count_q - (CW)'(1);
					end
				end
				S_INTCHK: begin
					if (idx_q == count_q || ram_rd.start >= iend) begin
						sum_q <= sum_q + 72'(acc_q * $signed({1'b0, seg_end}));
					end else begin
						idx_q <= idx_q + (CW)'(1);
						acc_q <= ram_rd.acc;
						if (ram_rd.start > pobs_time_q) begin
							if (ram_rd.start > cur_q)
								sum_q <= sum_q + 72'(acc_q * $signed({1'b0, seg_mid}));
							cur_q <= ram_rd.start;
						end
					end
				end
				S_DIVM: if (!dbusy && div_started_q) meas_q <= sat24(dquot);
				S_FILT: begin
					fm_q <= smooth(gain_q, pm, meas_q);
					fc_q <= smooth(gain_q, pc, sat24(dquot));
					ospeed_q <= val_q[AccW-1:0];
					obs_valid_q <= 1'b1;
					pobs_time_q <= et_q;
					pspeed_q <= val_q[AccW-1:0];
					ostatus_q <= ST_OBS_OK;
				end
				S_DONE: ovalid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_q <= s_axis_tuser;
			et_q <= s_axis_tdata[47:0];
			ot_q <= s_axis_tdata[95:48];
			val_q <= s_axis_tdata[120:96];
		end
	end

	wire obs_ok = (ostatus_q == ST_OBS_OK);
	assign m_axis_tdata = {5'd0,
		obs_ok ? fc_q : '0, obs_ok ? fm_q : '0, obs_ok ? ospeed_q : '0,
		obs_ok ? pobs_time_q : '0, ostatus_q};

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= (CW)'(CMD_DEPTH))
		else $error("command count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) ovalid_q |-> state_q == S_IDLE)
		else $error("result pending while busy");
	assert property (@(posedge clk) disable iff (!arst_n) obs_valid_q |-> pobs_valid_q)
		else $error("observation without previous sample");
endmodule
